[rtl/pbc_pkg.sv]
`timescale 1ns / 1ps

package pbc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CNT_W      = 16;
  localparam int LEVELS_W   = 11;
  localparam int VOICE_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // quantizer step index: |held * L / 32768| stays below 2048
  localparam int Q_W        = 12;
  localparam int PROD_W     = SAMPLE_W + LEVELS_W + 1;

  // divider: magnitude of q * 32768, two quotient bits per cycle
  localparam int DIVIDEND_W = (Q_W - 1) + 15;
  localparam int DIV_ITERS  = DIVIDEND_W / 2;
  localparam int DIV_CNT_W  = 4;

  localparam logic [CNT_W-1:0]    CNT_MAX        = '1;
  localparam logic [LEVELS_W-1:0] LEVELS_RST     = LEVELS_W'(1024);
  localparam logic [CNT_W-1:0]    HOLD_LIMIT_RST = '0;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_QUANT_LEVELS = CFG_IDX_W'(1);

  // one classified item on its way from the front end to the divider
  typedef struct packed {
    logic                oob;
    logic [Q_W-1:0]      q;
    logic [LEVELS_W-1:0] lv;
  } qent_t;

endpackage

[rtl/polyphonic_bitcrusher_core.sv]
`timescale 1ns / 1ps

// per-voice bitcrusher: each transfer names a voice and a q1.15 sample; the
// voice's hold counter advances (saturating at full scale) and, once it
// exceeds the hold limit, the sample is latched and the counter cleared. the
// held sample is quantized as q = floor(held*L/32768) and the result is
// floor(q*32768/L), with a level count of zero taken as one. an item for a
// voice at or above NUM_VOICES changes nothing and yields zero. every item
// gives exactly one result, in order. the front end moves each item through
// the voice ram read, the update and write-back, then the 16x12 multiply,
// and takes no new item until the current one has entered the queue; the
// back end divider produces 2 quotient bits per cycle over a 26-bit
// dividend, loading each item from the queue, running its iterations and
// handing the result to the output register, and the divider is the limit
// on the sustained item rate. a 2-entry queue between front end and divider
// and the output register let either side stall without stopping the other.
// configuration registers are written through cfg_* (always ready) and must
// only change while no item is in flight.

module polyphonic_bitcrusher_core #(
  parameter int NUM_VOICES = 9
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input item channel
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [pbc_pkg::VOICE_W-1:0]         in_voice,
  input  logic signed [pbc_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                in_hold_mod_valid,
  input  logic [pbc_pkg::CNT_W-1:0]           in_hold_mod,
  input  logic                                in_levels_mod_valid,
  input  logic [pbc_pkg::LEVELS_W-1:0]        in_levels_mod,
  // result channel
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [pbc_pkg::SAMPLE_W-1:0] out_crushed_sample,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pbc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [pbc_pkg::CNT_W-1:0]    hold_limit_r;
  logic [pbc_pkg::LEVELS_W-1:0] quant_levels_r;

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  pbc_pkg::qent_t q_wr_ent;
  pbc_pkg::qent_t q_rd_ent;

  // config registers, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_limit_r   <= pbc_pkg::HOLD_LIMIT_RST;
      quant_levels_r <= pbc_pkg::LEVELS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pbc_pkg::CFG_HOLD_LIMIT:   hold_limit_r   <= cfg_data;
        pbc_pkg::CFG_QUANT_LEVELS: quant_levels_r <= cfg_data[pbc_pkg::LEVELS_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: per-voice sample and hold, level select, step index
  pbc_front #(
    .NUM_VOICES (NUM_VOICES)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_voice            (in_voice),
    .in_sample_in        (in_sample_in),
    .in_hold_mod_valid   (in_hold_mod_valid),
    .in_hold_mod         (in_hold_mod),
    .in_levels_mod_valid (in_levels_mod_valid),
    .in_levels_mod       (in_levels_mod),
    .hold_limit          (hold_limit_r),
    .quant_levels        (quant_levels_r),
    .q_push              (q_push),
    .q_ent               (q_wr_ent),
    .q_full              (q_full)
  );

  // decoupling queue between the two halves
  pbc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_ent (q_wr_ent),
    .full   (q_full),
    .pop    (q_pop),
    .rd_ent (q_rd_ent),
    .empty  (q_empty)
  );

  // back end: floor division back to q1.15 and the output register
  pbc_div u_div (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_ent              (q_rd_ent),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_crushed_sample (out_crushed_sample)
  );

endmodule

[rtl/pbc_ram.sv]
`timescale 1ns / 1ps

module pbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 9
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/pbc_front.sv]
`timescale 1ns / 1ps

module pbc_front #(
  parameter int NUM_VOICES = 9
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [pbc_pkg::VOICE_W-1:0]     in_voice,
  input  logic signed [pbc_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                            in_hold_mod_valid,
  input  logic [pbc_pkg::CNT_W-1:0]       in_hold_mod,
  input  logic                            in_levels_mod_valid,
  input  logic [pbc_pkg::LEVELS_W-1:0]    in_levels_mod,
  input  logic [pbc_pkg::CNT_W-1:0]       hold_limit,
  input  logic [pbc_pkg::LEVELS_W-1:0]    quant_levels,
  output logic                            q_push,
  output pbc_pkg::qent_t                  q_ent,
  input  logic                            q_full
);

  localparam int VW   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int VX_W = 7;
  localparam int RW   = pbc_pkg::SAMPLE_W + pbc_pkg::CNT_W;

  typedef enum logic [1:0] {
    F_IDLE,
    F_UPD,
    F_MUL
  } fstate_t;

  fstate_t state_r;

  logic [NUM_VOICES-1:0]                vld_r;
  logic [VW-1:0]                        vaddr_r;
  logic                                 oob_r;
  logic signed [pbc_pkg::SAMPLE_W-1:0]  sample_r;
  logic [pbc_pkg::CNT_W-1:0]            limit_r;
  logic [pbc_pkg::LEVELS_W-1:0]         lv_r;
  logic signed [pbc_pkg::SAMPLE_W-1:0]  held_r;

  logic                                 accept;
  logic [VX_W-1:0]                      voice_ext;
  logic [VW-1:0]                        voice_addr;
  logic                                 voice_oob;
  logic [pbc_pkg::LEVELS_W-1:0]         lv_sel;
  logic [RW-1:0]                        ram_rdata;
  logic signed [pbc_pkg::SAMPLE_W-1:0]  held_old;
  logic [pbc_pkg::CNT_W-1:0]            cnt_old;
  logic [pbc_pkg::CNT_W-1:0]            cnt_inc;
  logic [pbc_pkg::CNT_W-1:0]            cnt_nxt;
  logic signed [pbc_pkg::SAMPLE_W-1:0]  held_nxt;
  logic signed [pbc_pkg::PROD_W-1:0]    prod;

  assign accept     = in_push && !in_full;
  assign in_full    = (state_r != F_IDLE);
  assign voice_ext  = {{(VX_W - pbc_pkg::VOICE_W){1'b0}}, in_voice};
  assign voice_addr = voice_ext[VW-1:0];
  assign voice_oob  = (voice_ext >= VX_W'(NUM_VOICES));
  assign lv_sel     = in_levels_mod_valid ? in_levels_mod : quant_levels;

  pbc_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_VOICES)
  ) u_state_ram (
    .clk   (clk),
    .we    ((state_r == F_UPD) && !oob_r),
    .waddr (vaddr_r),
    .wdata ({held_nxt, cnt_nxt}),
    .re    (accept),
    .raddr (voice_addr),
    .rdata (ram_rdata)
  );

  // an entry never written since reset reads as zero
  always_comb begin
    if (vld_r[vaddr_r]) begin
      held_old = ram_rdata[RW-1:pbc_pkg::CNT_W];
      cnt_old  = ram_rdata[pbc_pkg::CNT_W-1:0];
    end else begin
      held_old = '0;
      cnt_old  = '0;
    end
    cnt_inc = (cnt_old != pbc_pkg::CNT_MAX) ? cnt_old + 1'b1 : cnt_old;
    if (cnt_inc > limit_r) begin
      held_nxt = sample_r;
      cnt_nxt  = '0;
    end else begin
      held_nxt = held_old;
      cnt_nxt  = cnt_inc;
    end
  end

  // floor(held * L / 32768) is the arithmetic shift of the product
  assign prod     = held_r * $signed({1'b0, lv_r});
  assign q_ent.oob = oob_r;
  assign q_ent.q   = prod[pbc_pkg::Q_W+14:15];
  assign q_ent.lv  = lv_r;
  assign q_push    = (state_r == F_MUL) && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      vld_r   <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            vaddr_r  <= voice_addr;
            oob_r    <= voice_oob;
            sample_r <= in_sample_in;
            limit_r  <= in_hold_mod_valid ? in_hold_mod : hold_limit;
            lv_r     <= (lv_sel == '0) ? pbc_pkg::LEVELS_W'(1) : lv_sel;
            state_r  <= F_UPD;
          end
        end
        F_UPD: begin
          held_r <= held_nxt;
          if (!oob_r) begin
            vld_r[vaddr_r] <= 1'b1;
          end
          state_r <= F_MUL;
        end
        F_MUL: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/pbc_queue.sv]
`timescale 1ns / 1ps

module pbc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pbc_pkg::qent_t wr_ent,
  output logic           full,
  input  logic           pop,
  output pbc_pkg::qent_t rd_ent,
  output logic           empty
);

  pbc_pkg::qent_t ent_r [2];
  logic           wptr_r;
  logic           rptr_r;
  logic [1:0]     cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_ent  = ent_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wptr_r] <= wr_ent;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[rtl/pbc_div.sv]
`timescale 1ns / 1ps

module pbc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  pbc_pkg::qent_t                   q_ent,
  output logic                             q_pop,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic signed [pbc_pkg::SAMPLE_W-1:0] out_crushed_sample
);

  localparam int LW      = pbc_pkg::LEVELS_W;
  localparam int DW      = pbc_pkg::DIVIDEND_W;
  localparam int Q_MAG_W = pbc_pkg::Q_W - 1;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DONE
  } bstate_t;

  bstate_t state_r;

  logic [DW-1:0]                       quo_r;
  logic [LW-1:0]                       rem_r;
  logic [LW-1:0]                       div_r;
  logic                                neg_r;
  logic [pbc_pkg::DIV_CNT_W-1:0]       cnt_r;
  logic signed [pbc_pkg::SAMPLE_W-1:0] res_r;
  logic signed [pbc_pkg::SAMPLE_W-1:0] out_r;
  logic                                out_vld_r;

  logic [LW-1:0]                       rem_a;
  logic [LW-1:0]                       rem_nxt;
  logic                                qb_a;
  logic                                qb_b;
  logic [DW-1:0]                       quo_nxt;
  logic [LW:0]                         t_a;
  logic [LW:0]                         t_b;
  logic [Q_MAG_W-1:0]                  q_mag;
  logic [pbc_pkg::SAMPLE_W:0]          mag;
  logic [pbc_pkg::SAMPLE_W:0]          res_ext;
  logic                                out_free;

  // two restoring steps per cycle, dividend bits shift out the top of quo_r
  always_comb begin
    t_a = {rem_r, quo_r[DW-1]};
    if (t_a >= {1'b0, div_r}) begin
      qb_a  = 1'b1;
      rem_a = LW'(t_a - {1'b0, div_r});
    end else begin
      qb_a  = 1'b0;
      rem_a = t_a[LW-1:0];
    end
    t_b = {rem_a, quo_r[DW-2]};
    if (t_b >= {1'b0, div_r}) begin
      qb_b    = 1'b1;
      rem_nxt = LW'(t_b - {1'b0, div_r});
    end else begin
      qb_b    = 1'b0;
      rem_nxt = t_b[LW-1:0];
    end
    quo_nxt = {quo_r[DW-3:0], qb_a, qb_b};
  end

  // floor of a negative quotient rounds the magnitude up
  always_comb begin
    mag     = quo_nxt[pbc_pkg::SAMPLE_W:0]
              + (pbc_pkg::SAMPLE_W + 1)'(neg_r && (rem_nxt != '0));
    res_ext = neg_r ? (~mag + 1'b1) : mag;
  end

  assign q_mag     = q_ent.q[pbc_pkg::Q_W-1] ? Q_MAG_W'(-q_ent.q) : q_ent.q[Q_MAG_W-1:0];
  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign out_free  = !out_vld_r || out_pop;
  assign out_empty = !out_vld_r;
  assign out_crushed_sample = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      // set when a finished result moves in, cleared on a result transfer
      if ((state_r == B_DONE) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            if (q_ent.oob) begin
              res_r   <= '0;
              state_r <= B_DONE;
            end else begin
              quo_r   <= {q_mag, 15'b0};
              rem_r   <= '0;
              div_r   <= q_ent.lv;
              neg_r   <= q_ent.q[pbc_pkg::Q_W-1];
              cnt_r   <= '0;
              state_r <= B_RUN;
            end
          end
        end
        B_RUN: begin
          quo_r <= quo_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == pbc_pkg::DIV_CNT_W'(pbc_pkg::DIV_ITERS - 1)) begin
            res_r   <= res_ext[pbc_pkg::SAMPLE_W-1:0];
            state_r <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_r   <= res_r;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
